FILE: hdl/hdsr_pkg.sv
// ---------------------------------------------------------------------------
// hdsr_pkg: shared types, constants and step functions
// Widths, powers of ten and the per-stage arithmetic steps used by the
// digest-to-decimal-string reduction pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package hdsr_pkg;

  localparam int MAX_DIGITS  = 12;
  localparam int WORD_W      = 64;
  localparam int IDX_W       = 32;
  localparam int VAL_W       = 40;
  localparam int LEN_W       = 4;
  localparam int BCD_W       = 4 * MAX_DIGITS;
  localparam int DBL_W       = BCD_W + VAL_W;
  localparam int BITS_PER_ST = 8;
  localparam int MOD_STAGES  = WORD_W / BITS_PER_ST;
  localparam int BCD_STAGES  = VAL_W / BITS_PER_ST;

  // Data carried alongside an item through a pipelined unit
  typedef struct packed {
    logic [WORD_W-1:0] low;
    logic [LEN_W-1:0]  len;
  } hdsr_side_t;

  function automatic logic [VAL_W-1:0] pow_ten(input logic [LEN_W-1:0] k);
    logic [VAL_W-1:0] p;
    case (k)
      4'd0:    p = 40'd1;
      4'd1:    p = 40'd10;
      4'd2:    p = 40'd100;
      4'd3:    p = 40'd1000;
      4'd4:    p = 40'd10000;
      4'd5:    p = 40'd100000;
      4'd6:    p = 40'd1000000;
      4'd7:    p = 40'd10000000;
      4'd8:    p = 40'd100000000;
      4'd9:    p = 40'd1000000000;
      4'd10:   p = 40'd10000000000;
      4'd11:   p = 40'd100000000000;
      4'd12:   p = 40'd1000000000000;
      default: p = 40'd1000000000000;
    endcase
    return p;
  endfunction

  // Eight restoring long-division steps: fold in one byte of dividend
  function automatic logic [VAL_W-1:0] mod_step8(input logic [VAL_W-1:0] rem,
                                                 input logic [BITS_PER_ST-1:0] bits,
                                                 input logic [VAL_W-1:0] m);
    logic [VAL_W:0]   t;
    logic [VAL_W-1:0] r;
    r = rem;
    for (int i = BITS_PER_ST - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      r = t[VAL_W-1:0];
    end
    return r;
  endfunction

  // Eight double-dabble steps over {bcd, binary}
  function automatic logic [DBL_W-1:0] dabble_step8(input logic [DBL_W-1:0] s);
    logic [DBL_W-1:0] t;
    t = s;
    for (int i = 0; i < BITS_PER_ST; i++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (t[VAL_W + 4*d +: 4] >= 4'd5) begin
          t[VAL_W + 4*d +: 4] = t[VAL_W + 4*d +: 4] + 4'd3;
        end
      end
      t = t << 1;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hash_to_decimal_string_reduction_core.sv
// ---------------------------------------------------------------------------
// hash_to_decimal_string_reduction_core: digest to decimal string reduction
// Reduces a 128-bit digest plus chain index to a zero-padded ASCII decimal
// string of 1 to 12 characters, with its length and numeric value.
// ---------------------------------------------------------------------------
// Pipeline: 8 modulo stages on the high word, 1 length stage, 8 modulo
//   stages on the low word, 5 BCD stages, 1 output register.
// Throughput: one item per cycle while the output is not stalled; every stage
//   loads whenever it is empty or its successor moves, so bubbles close up under stall.
// Reset: synchronous, active low, clears all valid bits; data is not reset.
`default_nettype none

module hash_to_decimal_string_reduction_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_digest_low,
  input  wire logic [63:0] in_digest_high,
  input  wire logic [31:0] in_reduction_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_string_length,
  output logic [63:0]      out_chars_first_eight,
  output logic [31:0]      out_chars_last_four,
  output logic [39:0]      out_numeric_value
);
  import hdsr_pkg::*;

  // ---- stage group 1: high word modulo 10^12, low word rides along ----
  hdsr_side_t       hi_side_in;
  logic             hi_out_valid;
  logic             hi_out_stall;
  logic [VAL_W-1:0] hi_rem;
  hdsr_side_t       hi_side;

  // fold the chain index into the lowest digest word
  always_comb begin
    hi_side_in.low = in_digest_low ^ {{(WORD_W-IDX_W){1'b0}}, in_reduction_index};
    hi_side_in.len = '0;
  end

  hdsr_mod u_mod_hi (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_dividend (in_digest_high),
    .in_modulus  (pow_ten(LEN_W'(MAX_DIGITS))),
    .in_side     (hi_side_in),
    .out_valid   (hi_out_valid),
    .out_stall   (hi_out_stall),
    .out_rem     (hi_rem),
    .out_side    (hi_side)
  );

  // ---- length stage: count decimal digits, pick the low-word modulus ----
  logic             len_v_r;
  logic [LEN_W-1:0] len_nxt;
  logic [LEN_W-1:0] len_r;
  logic [WORD_W-1:0] low_r;
  logic [VAL_W-1:0] mod_r;
  logic             len_rdy;
  logic             lo_in_stall;
  hdsr_side_t       lo_side_in;

  // high value is below 10^12, so thresholds are monotonic: count them
  always_comb begin
    len_nxt = LEN_W'(1);
    for (int k = 1; k < MAX_DIGITS; k++) begin
      if (hi_rem >= pow_ten(LEN_W'(k))) begin
        len_nxt = len_nxt + LEN_W'(1);
      end
    end
  end

  assign len_rdy      = !len_v_r || !lo_in_stall;
  assign hi_out_stall = !len_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_v_r <= 1'b0;
    end else if (len_rdy) begin
      len_v_r <= hi_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (len_rdy) begin
      len_r <= len_nxt;
      low_r <= hi_side.low;
      mod_r <= pow_ten(len_nxt);
    end
  end

  always_comb begin
    lo_side_in.low = low_r;
    lo_side_in.len = len_r;
  end

  // ---- stage group 2: low word modulo 10^length ----
  logic             lo_out_valid;
  logic             lo_out_stall;
  logic [VAL_W-1:0] lo_rem;
  hdsr_side_t       lo_side;

  hdsr_mod u_mod_lo (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (len_v_r),
    .in_stall    (lo_in_stall),
    .in_dividend (low_r),
    .in_modulus  (mod_r),
    .in_side     (lo_side_in),
    .out_valid   (lo_out_valid),
    .out_stall   (lo_out_stall),
    .out_rem     (lo_rem),
    .out_side    (lo_side)
  );

  // ---- stage group 3: binary to BCD, value carried in the side word ----
  hdsr_side_t       bcd_side_in;
  logic             bcd_out_valid;
  logic             bcd_out_stall;
  logic [BCD_W-1:0] bcd_digits;
  hdsr_side_t       bcd_side;

  always_comb begin
    bcd_side_in.low = {{(WORD_W-VAL_W){1'b0}}, lo_rem};
    bcd_side_in.len = lo_side.len;
  end

  hdsr_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lo_out_valid),
    .in_stall  (lo_out_stall),
    .in_value  (lo_rem),
    .in_side   (bcd_side_in),
    .out_valid (bcd_out_valid),
    .out_stall (bcd_out_stall),
    .out_bcd   (bcd_digits),
    .out_side  (bcd_side)
  );

  // ---- output register: lay out ASCII, most significant digit first ----
  logic                      out_valid_r;
  logic                      out_rdy;
  logic [MAX_DIGITS*8-1:0]   chars_nxt;
  logic [MAX_DIGITS*8-1:0]   chars_r;
  logic [LEN_W-1:0]          olen_r;
  logic [VAL_W-1:0]          val_r;
  logic [LEN_W-1:0]          dig_idx;

  // character i takes digit (len-1-i); drop everything past the length
  always_comb begin
    chars_nxt = '0;
    dig_idx   = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (LEN_W'(i) < bcd_side.len) begin
        dig_idx            = bcd_side.len - LEN_W'(i) - LEN_W'(1);
        chars_nxt[8*i +: 8] = {4'h3, bcd_digits[4*dig_idx +: 4]};
      end
    end
  end

  assign out_rdy       = !out_valid_r || !out_stall;
  assign bcd_out_stall = !out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= bcd_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      chars_r <= chars_nxt;
      olen_r  <= bcd_side.len;
      val_r   <= bcd_side.low[VAL_W-1:0];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_string_length     = olen_r;
  assign out_chars_first_eight = chars_r[63:0];
  assign out_chars_last_four   = chars_r[MAX_DIGITS*8-1:64];
  assign out_numeric_value     = val_r;

  // ---- checks ----
  // back-pressure only ever starts from a full, stalled output register
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_string_length >= 4'd1 && out_string_length <= 4'd12))
    else $error("string length out of range");

  a_val_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_numeric_value < pow_ten(out_string_length)))
    else $error("numeric value wider than its string");

  a_first_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_chars_first_eight[7:4] == 4'h3))
    else $error("first character is not a digit");

endmodule

`default_nettype wire

FILE: hdl/hdsr_mod.sv
// ---------------------------------------------------------------------------
// hdsr_mod: pipelined 64-bit modulo unit
// Restoring remainder, one dividend byte per stage; the modulus travels
// with each item.
// ---------------------------------------------------------------------------
`default_nettype none

module hdsr_mod (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [hdsr_pkg::WORD_W-1:0]    in_dividend,
  input  wire logic [hdsr_pkg::VAL_W-1:0]     in_modulus,
  input  wire hdsr_pkg::hdsr_side_t           in_side,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [hdsr_pkg::VAL_W-1:0]          out_rem,
  output hdsr_pkg::hdsr_side_t                out_side
);
  import hdsr_pkg::*;

  localparam int NS = MOD_STAGES;

  logic [NS-1:0]     v_r;
  logic [NS-1:0]     rdy;
  logic [VAL_W-1:0]  rem_r  [NS];
  logic [WORD_W-1:0] dvd_r  [NS];
  logic [VAL_W-1:0]  m_r    [NS];
  hdsr_side_t        side_r [NS];

  logic [VAL_W-1:0]  rem_nxt  [NS];
  logic [WORD_W-1:0] dvd_nxt  [NS];
  logic [VAL_W-1:0]  m_nxt    [NS];
  hdsr_side_t        side_nxt [NS];
  logic [NS-1:0]     v_nxt;

  // a stage may load when empty or when the next one loads
  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || !out_stall;
    for (int s = NS - 2; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    v_nxt[0]    = in_valid;
    rem_nxt[0]  = mod_step8('0, in_dividend[WORD_W-1 -: BITS_PER_ST], in_modulus);
    dvd_nxt[0]  = in_dividend << BITS_PER_ST;
    m_nxt[0]    = in_modulus;
    side_nxt[0] = in_side;
    for (int s = 1; s < NS; s++) begin
      v_nxt[s]    = v_r[s-1];
      rem_nxt[s]  = mod_step8(rem_r[s-1], dvd_r[s-1][WORD_W-1 -: BITS_PER_ST], m_r[s-1]);
      dvd_nxt[s]  = dvd_r[s-1] << BITS_PER_ST;
      m_nxt[s]    = m_r[s-1];
      side_nxt[s] = side_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_nxt[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rdy[s]) begin
        rem_r[s]  <= rem_nxt[s];
        dvd_r[s]  <= dvd_nxt[s];
        m_r[s]    <= m_nxt[s];
        side_r[s] <= side_nxt[s];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_rem   = rem_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

`default_nettype wire

FILE: hdl/hdsr_bcd.sv
// ---------------------------------------------------------------------------
// hdsr_bcd: pipelined binary to BCD converter
// Double dabble over the 40-bit value, eight bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module hdsr_bcd (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [hdsr_pkg::VAL_W-1:0]     in_value,
  input  wire hdsr_pkg::hdsr_side_t           in_side,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [hdsr_pkg::BCD_W-1:0]          out_bcd,
  output hdsr_pkg::hdsr_side_t                out_side
);
  import hdsr_pkg::*;

  localparam int NS = BCD_STAGES;

  logic [NS-1:0]    v_r;
  logic [NS-1:0]    rdy;
  logic [DBL_W-1:0] st_r   [NS];
  hdsr_side_t       side_r [NS];

  logic [DBL_W-1:0] st_nxt   [NS];
  hdsr_side_t       side_nxt [NS];
  logic [NS-1:0]    v_nxt;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || !out_stall;
    for (int s = NS - 2; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    v_nxt[0]    = in_valid;
    st_nxt[0]   = dabble_step8({{BCD_W{1'b0}}, in_value});
    side_nxt[0] = in_side;
    for (int s = 1; s < NS; s++) begin
      v_nxt[s]    = v_r[s-1];
      st_nxt[s]   = dabble_step8(st_r[s-1]);
      side_nxt[s] = side_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_nxt[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rdy[s]) begin
        st_r[s]   <= st_nxt[s];
        side_r[s] <= side_nxt[s];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_bcd   = st_r[NS-1][DBL_W-1 -: BCD_W];
  assign out_side  = side_r[NS-1];

endmodule

`default_nettype wire

FILE: tb/hash_to_decimal_string_reduction_core_tb.sv
// ---------------------------------------------------------------------------
// hash_to_decimal_string_reduction_core_tb: self-checking bench
// Drives digests through the decimal-string reduction core: a directed table
// first, then random bursts. Every result item is compared with a behavioural
// prediction held in a queue, under random and long receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module hash_to_decimal_string_reduction_core_tb;

  typedef struct {
    logic [63:0] dlow;
    logic [63:0] dhigh;
    logic [31:0] idx;
    bit          typed;   // expected fields below are given in the table
    logic [3:0]  len;
    logic [63:0] c8;
    logic [31:0] c4;
    logic [39:0] val;
  } digest_row_t;

  typedef struct {
    logic [3:0]  len;
    logic [63:0] c8;
    logic [31:0] c4;
    logic [39:0] val;
  } decimal_str_t;

  localparam int    N_RANDOM    = 1500;
  localparam longint CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_digest_low = '0;
  logic [63:0] in_digest_high = '0;
  logic [31:0] in_reduction_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [3:0]  out_string_length;
  logic [63:0] out_chars_first_eight;
  logic [31:0] out_chars_last_four;
  logic [39:0] out_numeric_value;

  decimal_str_t expected_strings[$];
  int           fail_count = 0;
  bit           sending_done = 1'b0;
  longint       cycle_count = 0;

  hash_to_decimal_string_reduction_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the decimal string for one digest
  function automatic decimal_str_t reduce_digest(logic [63:0] dlow, logic [63:0] dhigh,
                                                 logic [31:0] idx);
    decimal_str_t r;
    longint unsigned ten_pow [13];
    longint unsigned lo, hi, v, rest;
    int n;
    ten_pow[0] = 1;
    for (int k = 1; k <= 12; k++) ten_pow[k] = ten_pow[k-1] * 10;
    lo = dlow ^ {32'd0, idx};
    hi = dhigh % ten_pow[hdsr_pkg::MAX_DIGITS];
    n = 1;
    while (n < hdsr_pkg::MAX_DIGITS && hi >= ten_pow[n]) n++;
    v = lo % ten_pow[n];
    r.len = n[3:0];
    r.val = v[39:0];
    r.c8 = '0;
    r.c4 = '0;
    rest = v;
    for (int i = n - 1; i >= 0; i--) begin
      if (i < 8) r.c8[8*i +: 8] = 8'h30 + 8'(rest % 10);
      else r.c4[8*(i-8) +: 8] = 8'h30 + 8'(rest % 10);
      rest = rest / 10;
    end
    return r;
  endfunction

  // Directed table: extremes, zero upper value, leading zeros, index XOR
  digest_row_t directed[] = '{
    '{64'd0, 64'd0, 32'd0, 1'b1, 4'd1, 64'h30, 32'h0, 40'd0},
    '{64'd7, 64'd0, 32'd0, 1'b1, 4'd1, 64'h37, 32'h0, 40'd7},
    '{64'd0, 64'd0, 32'd9, 1'b1, 4'd1, 64'h39, 32'h0, 40'd9},
    '{64'd5, 64'd10, 32'd0, 1'b1, 4'd2, 64'h3530, 32'h0, 40'd5},
    '{64'd0, 64'd999999999999, 32'd0, 1'b1, 4'd12, 64'h3030303030303030,
      32'h30303030, 40'd0},
    '{64'd1000000000000, 64'd1000000000000, 32'd0, 1'b1, 4'd1, 64'h30, 32'h0, 40'd0},
    '{'1, '1, '1, 1'b0, 4'd0, 64'd0, 32'd0, 40'd0},
    '{'1, '1, 32'd0, 1'b0, 4'd0, 64'd0, 32'd0, 40'd0},
    '{'0, '1, '1, 1'b0, 4'd0, 64'd0, 32'd0, 40'd0},
    '{64'h8000000000000000, 64'd99999999999, 32'h80000000, 1'b0, 4'd0, 64'd0, 32'd0, 40'd0},
    '{64'd123456789012, 64'd500000000000, 32'd0, 1'b1, 4'd12, 64'h3837363534333231,
      32'h32313039, 40'd123456789012},
    '{64'd42, 64'd99999999, 32'd0, 1'b0, 4'd0, 64'd0, 32'd0, 40'd0},
    '{64'hFFFFFFFF00000000, 64'd1999999999999, 32'h12345678, 1'b0, 4'd0, 64'd0, 32'd0, 40'd0},
    '{64'd100, 64'd1000, 32'd100, 1'b0, 4'd0, 64'd0, 32'd0, 40'd0}
  };

  // Offer one item and hold it until accepted; queue its expectation
  task automatic send_digest(logic [63:0] dlow, logic [63:0] dhigh, logic [31:0] idx,
                             decimal_str_t want);
    in_valid           <= 1'b1;
    in_digest_low      <= dlow;
    in_digest_high     <= dhigh;
    in_reduction_index <= idx;
    do @(posedge clk); while (in_stall);
    expected_strings.push_back(want);
  endtask

  // Insert a random idle gap, or none, between bursts
  task automatic sender_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Stimulus
  initial begin
    decimal_str_t want;
    logic [63:0] dl, dh;
    logic [31:0] ix;
    int burst;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      want = reduce_digest(directed[i].dlow, directed[i].dhigh, directed[i].idx);
      if (directed[i].typed) begin
        want.len = directed[i].len;
        want.c8  = directed[i].c8;
        want.c4  = directed[i].c4;
        want.val = directed[i].val;
      end
      send_digest(directed[i].dlow, directed[i].dhigh, directed[i].idx, want);
      sender_gap();
    end
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      dl = rand_word();
      ix = $urandom();
      // Spread the upper value over every length, plus full-range words
      case ($urandom_range(0, 3))
        0: dh = rand_word();
        1: dh = {$urandom(), $urandom()} % 64'd1000000000000;
        default: dh = rand_word() % (64'd10 ** $urandom_range(0, 13));
      endcase
      if ($urandom_range(0, 7) == 0) dl = 64'($urandom_range(0, 20));
      send_digest(dl, dh, ix, reduce_digest(dl, dh, ix));
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        sender_gap();
      end else begin
        burst--;
      end
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: stall pattern of its own, with one long hold-off
  initial begin
    int phase;
    int hold;
    phase = 0;
    @(posedge rst_n);
    while (1) begin
      @(posedge clk);
      phase++;
      if (phase == 300) begin
        // Hold off long enough for the pipeline to fill and stall its input
        out_stall <= 1'b1;
        hold = 0;
        while (hold < 80) begin
          @(posedge clk);
          hold++;
        end
      end
      if ((phase / 200) % 3 == 1) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk) begin
    decimal_str_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_strings.size() == 0) begin
        $error("result item with no expectation pending");
        fail_count++;
      end else begin
        e = expected_strings.pop_front();
        if (out_string_length !== e.len) begin
          $error("string_length exp %0d got %0d", e.len, out_string_length);
          fail_count++;
        end
        if (out_chars_first_eight !== e.c8) begin
          $error("chars_first_eight exp %h got %h", e.c8, out_chars_first_eight);
          fail_count++;
        end
        if (out_chars_last_four !== e.c4) begin
          $error("chars_last_four exp %h got %h", e.c4, out_chars_last_four);
          fail_count++;
        end
        if (out_numeric_value !== e.val) begin
          $error("numeric_value exp %0d got %0d", e.val, out_numeric_value);
          fail_count++;
        end
      end
    end
  end

  // Drain, then let the pipeline settle before the verdict
  initial begin
    wait (sending_done);
    while (expected_strings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

`default_nettype wire
